@@ rtl/rc4_pkg.sv @@
// Package with the shared types and constants of the RC4 engine.
package rc4_pkg;

  localparam int unsigned SBOX_N  = 256;
  localparam int unsigned SBOX_AW = 8;
  localparam int unsigned BYTE_W  = 8;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [SBOX_AW-1:0] raddr;
    logic               we;
    logic [SBOX_AW-1:0] waddr;
    byte_t              wdata;
    logic               clr;
  } sbox_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_D_RD_J,
    S_D_SWAP,
    S_D_WR_J,
    S_OUT,
    S_K_START,
    S_K_RD_N,
    S_K_RD_A,
    S_K_WR_N,
    S_K_WR_A
  } state_e;

  typedef enum logic [1:0] {
    FWD_NONE,
    FWD_SI,
    FWD_SJ
  } fwd_e;

endpackage

@@ rtl/rc4_if.sv @@
// Valid/ready channel interfaces for the input and result transactions of the RC4 engine.
interface rc4_in_if;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [rc4_pkg::BYTE_W-1:0] byte_in;
  logic                 end_of_run;

  modport source (output valid, output command, output byte_in, output end_of_run,
                  input ready);
  modport sink   (input valid, input command, input byte_in, input end_of_run,
                  output ready);
endinterface

interface rc4_out_if;
  logic                 valid;
  logic                 ready;
  logic [rc4_pkg::BYTE_W-1:0] byte_out;
  logic                 last_out;
  logic                 status;

  modport source (output valid, output byte_out, output last_out, output status,
                  input ready);
  modport sink   (input valid, input byte_out, input last_out, input status,
                  output ready);
endinterface

@@ rtl/rc4_sbox_mem.sv @@
// S-box memory with one read and one write port, registered read and per-entry valid bits.
module rc4_sbox_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rc4_pkg::sbox_req_t req_i,
  output rc4_pkg::byte_t     rdata_o
);

  rc4_pkg::byte_t               mem [rc4_pkg::SBOX_N];
  logic [rc4_pkg::SBOX_N-1:0]   valid_q;
  rc4_pkg::byte_t               rdata_q;
  logic [rc4_pkg::SBOX_AW-1:0]  raddr_q;
  logic                         rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
    raddr_q <= req_i.raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[req_i.raddr];
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  // An entry that was not written since the last clear holds the identity value.
  assign rdata_o = rvalid_q ? rdata_q : raddr_q;

endmodule

@@ rtl/rc4_key_mem.sv @@
// Key byte memory with one write port and one registered read port.
module rc4_key_mem #(
  parameter int unsigned KEY_DEPTH = 256,
  parameter int unsigned KIDX_W    = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [KIDX_W-1:0] waddr_i,
  input  rc4_pkg::byte_t    wdata_i,
  input  logic [KIDX_W-1:0] raddr_i,
  output rc4_pkg::byte_t    rdata_o
);

  rc4_pkg::byte_t mem [KEY_DEPTH];
  rc4_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rc4_stream_cipher_top.sv @@
// RC4 engine top level: the sequencer for key load, key schedule and keystream generation.
//
// A key byte is taken in the idle state, which stays idle for further key bytes unless the
// item ends the key. A keyed data byte passes S_D_RD_J, S_D_SWAP, S_D_WR_J and S_OUT, and a
// data byte before any key goes straight to S_OUT; the result is held in an output register,
// so a new byte is accepted while a result still waits. The item with the last key byte, and
// a keyed data byte that ends a message, start the key schedule; no input transaction is
// accepted during it. S_K_START clears the S-box valid bits, and each of the 256 swap steps
// runs S_K_RD_N, S_K_RD_A, S_K_WR_N and S_K_WR_A: two dependent reads and two writes back.
// Valid bits make the S-box read as the identity after reset, so no clearing pass runs.
module rc4_stream_cipher_top #(
  parameter int unsigned KEY_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc4_in_if.sink    in_i,
  rc4_out_if.source out_o
);

  localparam int unsigned KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(KEY_DEPTH + 1);
  localparam int unsigned AW     = rc4_pkg::SBOX_AW;

  rc4_pkg::state_e    state_q, state_d;
  rc4_pkg::fwd_e      fwd_q, fwd_d;
  rc4_pkg::sbox_req_t sreq;
  rc4_pkg::byte_t     srdata;
  rc4_pkg::byte_t     krdata;

  logic [AW-1:0]     i_q, i_d, j_q, j_d, n_q, n_d, acc_q, acc_d;
  rc4_pkg::byte_t    si_q, si_d, sj_q, sj_d;
  logic [KIDX_W-1:0] k_q, k_d;
  logic [CNT_W-1:0]  key_cnt_q, key_cnt_d;
  logic              keyed_q, keyed_d, loading_q, loading_d;
  rc4_pkg::byte_t    byte_q, byte_d, res_byte_q, res_byte_d;
  logic              last_q, last_d, res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  rc4_pkg::byte_t    out_byte_q;
  logic              out_last_q, out_status_q, out_load;

  logic              key_we;
  logic [KIDX_W-1:0] key_waddr;

  rc4_sbox_mem u_sbox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sreq),
    .rdata_o (srdata)
  );

  rc4_key_mem #(
    .KEY_DEPTH (KEY_DEPTH),
    .KIDX_W    (KIDX_W)
  ) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (in_i.byte_in),
    .raddr_i (k_q),
    .rdata_o (krdata)
  );

  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [AW-1:0]    t;
    logic [AW-1:0]    acc_n;
    rc4_pkg::byte_t   ks;

    state_d      = state_q;
    fwd_d        = fwd_q;
    i_d          = i_q;
    j_d          = j_q;
    n_d          = n_q;
    acc_d        = acc_q;
    si_d         = si_q;
    sj_d         = sj_q;
    k_d          = k_q;
    key_cnt_d    = key_cnt_q;
    keyed_d      = keyed_q;
    loading_d    = loading_q;
    byte_d       = byte_q;
    last_d       = last_q;
    res_byte_d   = res_byte_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    in_i.ready   = 1'b0;
    key_we       = 1'b0;
    key_waddr    = '0;
    sreq         = '0;
    cnt          = loading_q ? key_cnt_q : '0;
    t            = '0;
    acc_n        = '0;
    ks           = '0;

    unique case (state_q)
      rc4_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.command == rc4_pkg::CMD_KEY) begin
            loading_d = 1'b1;
            keyed_d   = 1'b0;
            key_cnt_d = cnt;
            if (cnt < CNT_W'(KEY_DEPTH)) begin
              key_we    = 1'b1;
              key_waddr = cnt[KIDX_W-1:0];
              key_cnt_d = cnt + CNT_W'(1);
            end
            if (in_i.end_of_run) begin
              state_d = rc4_pkg::S_K_START;
            end
          end else begin
            byte_d = in_i.byte_in;
            last_d = in_i.end_of_run;
            if (keyed_q) begin
              i_d        = i_q + AW'(1);
              sreq.raddr = i_q + AW'(1);
              state_d    = rc4_pkg::S_D_RD_J;
            end else begin
              res_byte_d   = in_i.byte_in;
              res_status_d = 1'b1;
              state_d      = rc4_pkg::S_OUT;
            end
          end
        end
      end
      rc4_pkg::S_D_RD_J: begin
        si_d       = srdata;
        j_d        = j_q + srdata;
        sreq.raddr = j_q + srdata;
        state_d    = rc4_pkg::S_D_SWAP;
      end
      rc4_pkg::S_D_SWAP: begin
        sj_d       = srdata;
        sreq.we    = 1'b1;
        sreq.waddr = i_q;
        sreq.wdata = srdata;
        t          = si_q + srdata;
        sreq.raddr = t;
        if (t == i_q) begin
          fwd_d = rc4_pkg::FWD_SJ;
        end else if (t == j_q) begin
          fwd_d = rc4_pkg::FWD_SI;
        end else begin
          fwd_d = rc4_pkg::FWD_NONE;
        end
        state_d = rc4_pkg::S_D_WR_J;
      end
      rc4_pkg::S_D_WR_J: begin
        sreq.we    = 1'b1;
        sreq.waddr = j_q;
        sreq.wdata = si_q;
        case (fwd_q)
          rc4_pkg::FWD_SI: ks = si_q;
          rc4_pkg::FWD_SJ: ks = sj_q;
          default:         ks = srdata;
        endcase
        res_byte_d   = byte_q ^ ks;
        res_status_d = 1'b0;
        state_d      = rc4_pkg::S_OUT;
      end
      rc4_pkg::S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = (last_q && !res_status_q) ? rc4_pkg::S_K_START : rc4_pkg::S_IDLE;
        end
      end
      rc4_pkg::S_K_START: begin
        sreq.clr = 1'b1;
        acc_d    = '0;
        n_d      = '0;
        k_d      = '0;
        state_d  = rc4_pkg::S_K_RD_N;
      end
      rc4_pkg::S_K_RD_N: begin
        sreq.raddr = n_q;
        state_d    = rc4_pkg::S_K_RD_A;
      end
      rc4_pkg::S_K_RD_A: begin
        si_d       = srdata;
        acc_n      = acc_q + srdata + krdata;
        acc_d      = acc_n;
        sreq.raddr = acc_n;
        state_d    = rc4_pkg::S_K_WR_N;
      end
      rc4_pkg::S_K_WR_N: begin
        sreq.we    = 1'b1;
        sreq.waddr = n_q;
        sreq.wdata = srdata;
        state_d    = rc4_pkg::S_K_WR_A;
      end
      rc4_pkg::S_K_WR_A: begin
        sreq.we    = 1'b1;
        sreq.waddr = acc_q;
        sreq.wdata = si_q;
        n_d        = n_q + AW'(1);
        if (CNT_W'(k_q) + CNT_W'(1) >= key_cnt_q) begin
          k_d = '0;
        end else begin
          k_d = k_q + KIDX_W'(1);
        end
        if (n_q == AW'(rc4_pkg::SBOX_N - 1)) begin
          i_d       = '0;
          j_d       = '0;
          keyed_d   = 1'b1;
          loading_d = 1'b0;
          state_d   = rc4_pkg::S_IDLE;
        end else begin
          state_d = rc4_pkg::S_K_RD_N;
        end
      end
      default: begin
        state_d = rc4_pkg::S_IDLE;
      end
    endcase

    out_valid_d = (out_valid_q && !out_o.ready) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc4_pkg::S_IDLE;
      fwd_q       <= rc4_pkg::FWD_NONE;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      acc_q       <= '0;
      k_q         <= '0;
      key_cnt_q   <= '0;
      keyed_q     <= 1'b0;
      loading_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fwd_q       <= fwd_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      acc_q       <= acc_d;
      k_q         <= k_d;
      key_cnt_q   <= key_cnt_d;
      keyed_q     <= keyed_d;
      loading_q   <= loading_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q         <= si_d;
    sj_q         <= sj_d;
    byte_q       <= byte_d;
    last_q       <= last_d;
    res_byte_q   <= res_byte_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_byte_q   <= res_byte_q;
      out_last_q   <= last_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.byte_out = out_byte_q;
  assign out_o.last_out = out_last_q;
  assign out_o.status   = out_status_q;

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == rc4_pkg::S_OUT))
    else $error("Result transaction appeared outside the output state.");

  a_schedule_end_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::S_K_WR_A && n_q == AW'(rc4_pkg::SBOX_N - 1))
      |=> (keyed_q && !loading_q && i_q == '0 && j_q == '0))
    else $error("Key schedule ended without a clean keyed state.");

  a_new_key_drops_old: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.command == rc4_pkg::CMD_KEY) |=> !keyed_q)
    else $error("A key byte left the old key in use.");

  a_unkeyed_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.command == rc4_pkg::CMD_DATA && !keyed_q)
      |=> (state_q == rc4_pkg::S_OUT && res_status_q && res_byte_q == $past(in_i.byte_in)))
    else $error("Data without a key was not passed through with error status.");

  a_no_accept_in_schedule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::S_K_RD_N || state_q == rc4_pkg::S_K_WR_A) |-> !in_i.ready)
    else $error("Input transaction offered during the key schedule.");

endmodule
